/* rtl/core/sha256_pkg.sv */
// SHA-256 constants, round constant table and round helper functions.
// No dependencies.
package sha256_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_EMIT
  } state_e;

  localparam logic [255:0] IvFlat = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] iv_word(input logic [2:0] idx);
    iv_word = IvFlat[(7 - idx) * 32 +: 32];
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    unique case (r)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
      6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
      6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
      6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
      6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    round_k = k;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

/* rtl/core/sha256_round.sv */
// One SHA-256 round: schedule update and working variable step.
// Depends on sha256_pkg.
module sha256_round import sha256_pkg::*; (
  input  logic [5:0]          round_i,
  input  logic [15:0][31:0]   w_i,
  input  logic [7:0][31:0]    v_i,
  output logic [15:0][31:0]   w_o,
  output logic [7:0][31:0]    v_o
);
  logic [31:0] w2, w15, s0, s1, wn, e, a, t1, t2;

  always_comb begin
    // w_i[0] is the oldest word; the window shifts down every round
    w2  = w_i[14];
    w15 = w_i[1];
    s1  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
    s0  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
    wn  = (round_i < 6'd16) ? w_i[0] : s1 + w_i[9] + s0 + w_i[0];
    e   = v_i[4];
    a   = v_i[0];
    t1  = v_i[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
        + ((e & v_i[5]) ^ (~e & v_i[6])) + round_k(round_i) + wn;
    t2  = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
        + ((a & v_i[1]) ^ (a & v_i[2]) ^ (v_i[1] & v_i[2]));
    w_o = {wn, w_i[15:1]};
    v_o = {v_i[6:4], v_i[3] + t1, v_i[2:0], t1 + t2};
  end
endmodule

/* rtl/core/sha256_message_digest.sv */
// SHA-256 digest engine, byte input, word output.
// Depends on sha256_pkg and sha256_round.
//
//   channel  dir  fields
//   in       in   msg_byte_i, byte_present_i, end_of_message_i
//   out      out  digest_word_o, word_index_o, last_word_o
//
// A byte that does not fill a block is stored and the engine stays in idle. A
// byte that fills a block is stored, then the block runs the round and add
// states on the shared round unit. End of message runs the pad, round and add
// states per padding block (one or two), then eight output words. in_ready_o
// is low until the engine is back in idle; out stalls hold the current word.
// Reset loads the initial hash.
module sha256_message_digest import sha256_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  msg_byte_i,
  input  logic        byte_present_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);
  state_e state_q, state_d;
  logic [7:0][31:0]  h_q;
  logic [7:0][31:0]  v_q;
  logic [15:0][31:0] w_q;
  logic [15:0][31:0] w_nx;
  logic [7:0][31:0]  v_nx;
  logic [31:0] cnt_q;
  logic [5:0]  rnd_q;
  logic [2:0]  idx_q;
  logic        fin_q;   // message ended, padding pending
  logic        len_q;   // current compression holds the length field
  logic [5:0]  pos;
  logic [1:0]  lane;
  logic in_acc, out_acc;
  logic [31:0] cnt_inc;

  sha256_round u_round (
    .round_i(rnd_q), .w_i(w_q), .v_i(v_q), .w_o(w_nx), .v_o(v_nx)
  );

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;
  assign pos     = cnt_q[5:0];
  assign lane    = 2'd3 - pos[1:0];
  assign cnt_inc = cnt_q + 32'd1;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (byte_present_i && cnt_inc[5:0] == 6'd0) state_d = ST_ROUND;
          else if (end_of_message_i) state_d = ST_PAD;
        end
      end
      ST_ROUND: if (rnd_q == 6'd63) state_d = ST_ADD;
      ST_ADD: begin
        if (len_q) state_d = ST_EMIT;
        else if (fin_q) state_d = ST_PAD;
        else state_d = ST_IDLE;
      end
      ST_PAD:  state_d = ST_ROUND;
      ST_EMIT: if (out_acc && idx_q == 3'd7) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = (state_q == ST_IDLE);
    out_valid_o   = (state_q == ST_EMIT);
    digest_word_o = h_q[idx_q];
    word_index_o  = idx_q;
    last_word_o   = (idx_q == 3'd7);
  end

  // schedule words double as the block buffer, big-endian within each word
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_acc && byte_present_i) begin
      w_q[pos[5:2]][{lane, 3'b000} +: 8] <= msg_byte_i;
      if (cnt_inc[5:0] == 6'd0) v_q <= h_q;
    end else if (state_q == ST_PAD) begin
      // pos is where 0x80 goes unless it already went into a prior block
      for (int i = 0; i < 16; i++) begin
        logic [31:0] wd;
        wd = 32'h0;
        for (int j = 0; j < 4; j++) begin
          logic [7:0] b;
          b = 8'h00;
          if (!len_q) begin
            if (6'(4*i+j) < pos) b = w_q[i][31-8*j -: 8];
            else if (6'(4*i+j) == pos) b = 8'h80;
          end
          wd[31-8*j -: 8] = b;
        end
        if (i == 15 && (len_q || pos < 6'd56)) wd = {cnt_q[28:0], 3'b000};
        w_q[i] <= wd;
      end
      v_q <= h_q;
    end else if (state_q == ST_ROUND) begin
      w_q <= w_nx;
      v_q <= v_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= 32'd0;
      rnd_q   <= 6'd0;
      idx_q   <= 3'd0;
      fin_q   <= 1'b0;
      len_q   <= 1'b0;
      for (int i = 0; i < 8; i++) h_q[i] <= iv_word(3'(i));
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE: if (in_acc) begin
          if (byte_present_i) cnt_q <= cnt_inc;
          fin_q <= end_of_message_i;
          len_q <= 1'b0;
        end
        ST_PAD: begin
          rnd_q <= 6'd0;
          // the length fits here; else this block ends in 0x80 and zeros, no length
          if (len_q || pos < 6'd56) len_q <= 1'b1;
          else fin_q <= 1'b1;
        end
        ST_ROUND: rnd_q <= rnd_q + 6'd1;
        ST_ADD: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
          // after a spill block the length block follows with no marker
          if (fin_q && !len_q && pos >= 6'd56) len_q <= 1'b1;
          idx_q <= 3'd0;
        end
        ST_EMIT: if (out_acc) begin
          idx_q <= idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            for (int i = 0; i < 8; i++) h_q[i] <= iv_word(3'(i));
            cnt_q <= 32'd0;
            fin_q <= 1'b0;
            len_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

/* rtl/core/sha256_checker.sv */
// Port-level checks for sha256_message_digest.
// Depends on nothing; bound to the top level below.
module sha256_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] digest_word_o,
  input logic [2:0]  word_index_o,
  input logic        last_word_o
);
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("input open during output");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_word_o == (word_index_o == 3'd7))) else $error("last flag");
  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_word_o) |=>
      (out_valid_o && word_index_o == $past(word_index_o) + 3'd1)) else $error("index step");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(digest_word_o)) else $error("word moved");
endmodule

bind sha256_message_digest sha256_checker u_checker (.*);
